[design/byte_level_unicode_to_bytes_decoder_defines.svh]
// assertion macros used by the decoder top level
`ifndef BYTE_LEVEL_UNICODE_TO_BYTES_DECODER_DEFINES_SVH
`define BYTE_LEVEL_UNICODE_TO_BYTES_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BLD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bld_pkg.sv]
package bld_pkg;

  // default depth of the queue between front and back
  localparam int unsigned BldQueueDepth = 2;

  // substitution byte
  localparam logic [7:0] QMark = 8'h3F;

  // widest code point: 3 + 3 * 6 bits
  localparam int unsigned CpWidth = 21;

  // one character job: buffered bytes plus the new one
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            fin;
  } bld_job_t;

  // front status seen by the top level
  typedef struct packed {
    logic [1:0] pend_cnt;
  } bld_front_stat_t;

  // result of the inverse table lookup
  typedef struct packed {
    logic       ok;
    logic [7:0] raw;
  } bld_map_t;

  // character length from the lead byte alone
  function automatic logic [2:0] char_length(input logic [7:0] lead);
    logic [2:0] len;
    if (!lead[7]) len = 3'd1;
    else if (lead[7:5] == 3'b110) len = 3'd2;
    else if (lead[7:4] == 4'b1110) len = 3'd3;
    else len = 3'd4;
    return len;
  endfunction

  // payload bits of the lead and low six bits of each following byte
  function automatic logic [CpWidth-1:0] code_point(input logic [3:0][7:0] s,
                                                   input logic [2:0] len);
    logic [CpWidth-1:0] cp;
    case (len)
      3'd1: cp = {13'b0, s[0]};
      3'd2: cp = {10'b0, s[0][4:0], s[1][5:0]};
      3'd3: cp = {5'b0, s[0][3:0], s[1][5:0], s[2][5:0]};
      default: cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
    endcase
    return cp;
  endfunction

  // inverse of the byte-to-unicode table
  function automatic bld_map_t map_back(input logic [CpWidth-1:0] cp);
    bld_map_t   m;
    logic [7:0] n;
    n = {1'b0, cp[6:0]};
    m.ok  = 1'b1;
    m.raw = cp[7:0];
    if ((cp >= CpWidth'(8'h21) && cp <= CpWidth'(8'h7E)) ||
        (cp >= CpWidth'(8'hA1) && cp <= CpWidth'(8'hAC)) ||
        (cp >= CpWidth'(8'hAE) && cp <= CpWidth'(8'hFF))) begin
      m.raw = cp[7:0];
    end else if (cp >= CpWidth'(256) && cp <= CpWidth'(256 + 67)) begin
      // nth non-printable byte in ascending order
      if (n < 8'd33) m.raw = n;
      else if (n < 8'd67) m.raw = n + 8'h5E;
      else m.raw = 8'hAD;
    end else begin
      m.ok  = 1'b0;
      m.raw = QMark;
    end
    return m;
  endfunction

endpackage

[design/bld_in_if.sv]
interface bld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

[design/bld_out_if.sv]
interface bld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       substituted;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_byte, output substituted, output run_end,
                  output string_end, input ready);
  modport sink (input valid, input out_byte, input substituted, input run_end,
                input string_end, output ready);
endinterface

[design/bld_front.sv]
module bld_front import bld_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  bld_in_if.sink          in_i,
  output logic            job_valid_o,
  output bld_job_t        job_o,
  input  logic            job_ready_i,
  output bld_front_stat_t stat_o
);

  logic [1:0] pend_cnt_q, pend_cnt_d;
  logic [7:0] pend_q [3];
  logic [7:0] lead;
  logic [2:0] cnt_new;
  logic       complete;
  logic       accept;

  // classify the incoming byte against the unfinished character
  always_comb begin
    lead     = (pend_cnt_q == 2'd0) ? in_i.in_byte : pend_q[0];
    cnt_new  = {1'b0, pend_cnt_q} + 3'd1;
    complete = in_i.is_final || (char_length(lead) == cnt_new);
    accept   = in_i.valid && job_ready_i;
  end

  // build the job from buffered bytes and the new byte
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < pend_cnt_q) job_o.bytes[k] = pend_q[k];
      else if (2'(k) == pend_cnt_q) job_o.bytes[k] = in_i.in_byte;
      else job_o.bytes[k] = 8'h00;
    end
    job_o.bytes[3] = (pend_cnt_q == 2'd3) ? in_i.in_byte : 8'h00;
    job_o.cnt      = cnt_new;
    job_o.fin      = in_i.is_final;
  end

  assign job_valid_o = in_i.valid && complete;
  assign in_i.ready  = job_ready_i;

  // pending count update
  always_comb begin
    pend_cnt_d = pend_cnt_q;
    if (accept) begin
      pend_cnt_d = complete ? 2'd0 : pend_cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= 2'd0;
    end else begin
      pend_cnt_q <= pend_cnt_d;
    end
  end

  // buffer bytes of an unfinished character
  always_ff @(posedge clk_i) begin
    if (accept && !complete) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) == pend_cnt_q) pend_q[k] <= in_i.in_byte;
      end
    end
  end

  assign stat_o.pend_cnt = pend_cnt_q;

endmodule

[design/bld_queue.sv]
module bld_queue import bld_pkg::*; #(
  parameter int unsigned Depth = BldQueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  input  bld_job_t push_data_i,
  output logic     push_ready_o,
  output logic     pop_valid_o,
  output bld_job_t pop_data_o,
  input  logic     pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bld_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop) rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[design/bld_back.sv]
module bld_back import bld_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  bld_job_t job_i,
  output logic     job_ready_o,
  bld_out_if.source out_o
);

  logic [1:0]         pos_q, pos_d;
  logic [31:0]        shifted;
  logic [3:0][7:0]    sel;
  logic [2:0]         len, rem, step, new_pos;
  logic [CpWidth-1:0] cp;
  bld_map_t           map;
  logic [7:0]         res_byte;
  logic               res_sub, last, advance;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_sub_q, out_run_q, out_str_q;

  // decode one character starting at the current position
  always_comb begin
    shifted = job_i.bytes >> {pos_q, 3'b000};
    sel     = shifted;
    len     = char_length(sel[0]);
    rem     = job_i.cnt - {1'b0, pos_q};
    cp      = code_point(sel, len);
    map     = map_back(cp);
    if (len <= rem) begin
      res_sub  = !map.ok;
      res_byte = map.ok ? map.raw : QMark;
      step     = len;
    end else begin
      // truncated at end of string: lead byte alone gives a substitute
      res_sub  = 1'b1;
      res_byte = QMark;
      step     = 3'd1;
    end
    new_pos = {1'b0, pos_q} + step;
    last    = (new_pos >= job_i.cnt);
  end

  // step when a job waits and the output slot is free or draining
  always_comb begin
    advance     = job_valid_i && (!out_valid_q || out_o.ready);
    job_ready_o = advance && last;
    pos_d       = pos_q;
    if (advance) pos_d = last ? 2'd0 : new_pos[1:0];
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= res_byte;
      out_sub_q  <= res_sub;
      out_run_q  <= last;
      out_str_q  <= last && job_i.fin;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.substituted = out_sub_q;
  assign out_o.run_end     = out_run_q;
  assign out_o.string_end  = out_str_q;

endmodule

[design/byte_level_unicode_to_bytes_decoder.sv]
// accepts one byte per cycle while the job queue has room
// a completed character goes through the job queue and the back end's output register
// the back end gives one result per cycle while its output is taken; a truncated
// tail at string end gives its lead byte as a substitute and decodes the rest
// reset clears the pending count, the queue and the output valid
`include "byte_level_unicode_to_bytes_decoder_defines.svh"

module byte_level_unicode_to_bytes_decoder import bld_pkg::*; #(
  parameter int unsigned QueueDepth = BldQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bld_in_if.sink    in_i,
  bld_out_if.source out_o
);

  logic            job_valid, job_ready;
  bld_job_t        job;
  logic            head_valid, head_ready;
  bld_job_t        head;
  bld_front_stat_t front_stat;

  // accept and classify bytes
  bld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready),
    .stat_o      (front_stat)
  );

  // decouple front and back
  bld_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_data_i  (job),
    .push_ready_o (job_ready),
    .pop_valid_o  (head_valid),
    .pop_data_o   (head),
    .pop_ready_i  (head_ready)
  );

  // decode characters into raw bytes
  bld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head),
    .job_ready_o (head_ready),
    .out_o       (out_o)
  );

  // a final byte always leaves no pending character
  `BLD_ASSERT_NEXT(a_final_clears, clk_i, rst_ni,
                   in_i.valid && in_i.ready && in_i.is_final,
                   front_stat.pend_cnt == 2'd0, "pending bytes left after final byte")

  // a job that is not at string end carries exactly one whole character
  `BLD_ASSERT_IMPL(a_job_complete, clk_i, rst_ni, job_valid && !job.fin,
                   char_length(job.bytes[0]) == job.cnt,
                   "incomplete character queued mid-string")

  // a queued job always has its new byte counted
  `BLD_ASSERT_IMPL(a_head_cnt, clk_i, rst_ni, head_valid,
                   head.cnt != 3'd0 && head.cnt <= 3'd4, "queued job with bad byte count")

endmodule

[bench/tb_byte_level_unicode_to_bytes_decoder.sv]
module tb_byte_level_unicode_to_bytes_decoder;
  import bld_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // first code point of the non-printable block and its size
  localparam int unsigned NonPrintBase  = 256;
  localparam int unsigned NonPrintCount = 68;
  localparam int unsigned RandomItems   = 340;
  localparam int unsigned QuietItems    = 60;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       substituted;
    logic       run_end;
    logic       string_end;
  } dec_result_t;

  logic clk;
  logic rst_n;

  bld_in_if  in_ch ();
  bld_out_if out_ch ();

  byte_level_unicode_to_bytes_decoder u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // decoded bytes still to come out of the block
  dec_result_t decoded_q[$];
  dec_result_t want_r;

  // mirror of the unfinished character
  logic [7:0] pend_bytes[3];
  logic [1:0] pend_cnt = 2'd0;

  int err_count     = 0;
  int bytes_sent    = 0;
  bit src_gaps_on   = 1'b0;
  bit sink_stalls_on = 1'b0;
  int hold_left     = 0;
  int stall_left    = 0;

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // overall time limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // appends one byte at the end of a string
  function automatic void append_byte(ref logic [7:0] s[$], input logic [7:0] b);
    s.insert(s.size(), b);
  endfunction

  // works out the results that one accepted byte causes
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    logic [7:0]  chars[4];
    dec_result_t res[3];
    logic [20:0] cp;
    int unsigned cnt, pos, len, k, nres, n;
    cnt = pend_cnt;
    for (k = 0; k < cnt; k++) chars[k] = pend_bytes[k];
    chars[cnt] = b;
    cnt++;
    pos  = 0;
    nres = 0;
    while (pos < cnt && nres < 3) begin
      // lead byte alone decides the length
      if (!chars[pos][7]) len = 1;
      else if (chars[pos][7:5] == 3'b110) len = 2;
      else if (chars[pos][7:4] == 4'b1110) len = 3;
      else len = 4;
      res[nres] = '{out_byte: QMark, substituted: 1'b1, run_end: 1'b0, string_end: 1'b0};
      if (len <= cnt - pos) begin
        case (len)
          1: cp = 21'(chars[pos]);
          2: cp = 21'({chars[pos][4:0], chars[pos+1][5:0]});
          3: cp = 21'({chars[pos][3:0], chars[pos+1][5:0], chars[pos+2][5:0]});
          default: cp = {chars[pos][2:0], chars[pos+1][5:0], chars[pos+2][5:0],
                         chars[pos+3][5:0]};
        endcase
        if ((cp >= 21'h21 && cp <= 21'h7E) || (cp >= 21'hA1 && cp <= 21'hAC) ||
            (cp >= 21'hAE && cp <= 21'hFF)) begin
          res[nres].out_byte    = cp[7:0];
          res[nres].substituted = 1'b0;
        end else if (cp >= NonPrintBase && cp < NonPrintBase + NonPrintCount) begin
          // nth non-printable byte, ascending
          n = cp - NonPrintBase;
          if (n < 33) res[nres].out_byte = 8'(n);
          else if (n < 67) res[nres].out_byte = 8'(8'h7F + (n - 33));
          else res[nres].out_byte = 8'hAD;
          res[nres].substituted = 1'b0;
        end
        pos += len;
      end else if (fin) begin
        // truncated tail: lead gives a substitute, the rest is decoded again
        pos += 1;
      end else begin
        break;
      end
      nres++;
    end
    pend_cnt = 2'd0;
    if (!fin) begin
      k = 0;
      while (pos + k < cnt && k < 3) begin
        pend_bytes[k] = chars[pos + k];
        k++;
      end
      pend_cnt = 2'(k);
    end
    if (nres > 0) begin
      res[nres-1].run_end    = 1'b1;
      res[nres-1].string_end = fin;
    end
    for (k = 0; k < nres; k++) decoded_q.insert(decoded_q.size(), res[k]);
  endfunction

  // one request on the input channel, with an optional gap in front
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (src_gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= b;
    in_ch.is_final <= fin;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // sender holds off until every decoded byte has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // receiver side: random stalls and the long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare every result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %h", out_ch.out_byte));
      end else begin
        want_r = decoded_q.pop_front();
        if (out_ch.out_byte !== want_r.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", out_ch.out_byte,
                                    want_r.out_byte));
        if (out_ch.substituted !== want_r.substituted)
          report_mismatch($sformatf("substituted %b, want %b", out_ch.substituted,
                                    want_r.substituted));
        if (out_ch.run_end !== want_r.run_end)
          report_mismatch($sformatf("run_end %b, want %b", out_ch.run_end,
                                    want_r.run_end));
        if (out_ch.string_end !== want_r.string_end)
          report_mismatch($sformatf("string_end %b, want %b", out_ch.string_end,
                                    want_r.string_end));
      end
    end
  end

  // one-byte strings at the edges of the printable range
  task automatic test_single_bytes();
    logic [7:0] vals[4];
    vals = '{8'h00, 8'h21, 8'h7E, 8'h7F};
    foreach (vals[i]) send_byte(vals[i], 1'b1);
    wait_drained();
  endtask

  // two-byte characters in one string: block ends, printable and unmappable
  task automatic test_two_byte();
    logic [7:0] s[$];
    s = '{8'hC4, 8'h80, 8'hC5, 8'h83, 8'hC5, 8'h84, 8'hC3, 8'hBF};
    send_string(s);
    wait_drained();
  endtask

  // overlong three-byte form and a code point above the plane
  task automatic test_long_forms();
    logic [7:0] s[$];
    s = '{8'hE0, 8'h84, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80};
    send_string(s);
    wait_drained();
  endtask

  // strings that stop inside a character
  task automatic test_truncated_tail();
    logic [7:0] s[$];
    s = '{8'hE2, 8'h82};
    send_string(s);
    s = '{8'hF0, 8'h41, 8'h42};
    send_string(s);
    s = '{8'hC3};
    send_string(s);
    wait_drained();
  endtask

  // random string: mostly well-formed characters, some noise, some cut short
  task automatic send_random_string();
    logic [7:0]  s[$];
    logic [20:0] cp;
    logic [7:0]  lead;
    int nchars, kind, extra;
    nchars = $urandom_range(1, 5);
    for (int c = 0; c < nchars; c++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: append_byte(s, 8'($urandom_range(0, 127)));
        3, 4: begin
          cp = 21'(NonPrintBase + $urandom_range(0, NonPrintCount - 1));
          append_byte(s, {3'b110, cp[10:6]});
          append_byte(s, {2'b10, cp[5:0]});
        end
        5: begin
          cp = 21'($urandom_range(0, 12'h7FF));
          append_byte(s, {3'b110, cp[10:6]});
          append_byte(s, {2'b10, cp[5:0]});
        end
        6: begin
          cp = 21'($urandom_range(0, 16'hFFFF));
          append_byte(s, {4'b1110, cp[15:12]});
          append_byte(s, {2'b10, cp[11:6]});
          append_byte(s, {2'b10, cp[5:0]});
        end
        7: begin
          // any four-byte lead, continuation bits not checked
          if ($urandom_range(0, 1)) append_byte(s, 8'($urandom_range(8'hF0, 8'hFF)));
          else append_byte(s, 8'($urandom_range(8'h80, 8'hBF)));
          repeat (3) append_byte(s, 8'($urandom_range(0, 255)));
        end
        8: append_byte(s, 8'($urandom_range(0, 255)));
        default: begin
          append_byte(s, 8'($urandom_range(8'hC0, 8'hDF)));
          append_byte(s, 8'($urandom_range(0, 255)));
        end
      endcase
    end
    // sometimes leave the last character unfinished
    if ($urandom_range(0, 5) == 0) begin
      lead = 8'($urandom_range(8'h80, 8'hFF));
      append_byte(s, lead);
      if (lead[7:5] == 3'b110) extra = 0;
      else if (lead[7:4] == 4'b1110) extra = $urandom_range(0, 1);
      else extra = $urandom_range(0, 2);
      repeat (extra) append_byte(s, 8'($urandom_range(0, 255)));
    end
    send_string(s);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    hold_left      = 60;
    repeat (8) send_random_string();
    wait_drained();
  endtask

  // random strings with idling on both sides, then a stretch without
  task automatic test_random_strings();
    int start;
    start          = bytes_sent;
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    while (bytes_sent - start < RandomItems) begin
      if (bytes_sent - start >= RandomItems - QuietItems) begin
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
      end
      send_random_string();
      if ($urandom_range(0, 14) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= 8'h00;
    in_ch.is_final <= 1'b0;
    @(posedge clk iff rst_n);
    test_single_bytes();
    test_two_byte();
    test_long_forms();
    test_truncated_tail();
    test_backpressure();
    test_random_strings();
    repeat (20) @(posedge clk);
    if (decoded_q.size() != 0) report_mismatch("expected results left over");
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
